FILE: hw/rtl/selective_repeat_receiver_assert.svh
// Assertion macros for the selective-repeat receiver.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked out of reset.
`define SRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/srr_pkg.sv
// Shared constants and codes for the selective-repeat receiver.
// Depends on nothing.
package srr_pkg;
   localparam int SEQ_SPACE    = 8;
   localparam int SEQ_BITS     = 3;
   localparam int HALF_SPACE   = SEQ_SPACE / 2;
   localparam int PAYLOAD_BITS = 32;
   localparam int WIN_BITS     = 3;
   localparam int CNT_BITS     = $clog2(HALF_SPACE + 1);

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(HALF_SPACE);
endpackage

FILE: hw/rtl/srr_if.sv
// Request and response channel interfaces of the selective-repeat receiver.
// Depends on srr_pkg for field widths.
interface srr_req_if import srr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SEQ_BITS-1:0]     seq_num;
   logic [PAYLOAD_BITS-1:0] payload;
   logic                    checksum_ok;

   modport source (output valid, seq_num, payload, checksum_ok, input ready);
   modport sink   (input valid, seq_num, payload, checksum_ok, output ready);
endinterface

interface srr_rsp_if import srr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [SEQ_BITS-1:0]     number;
   logic [PAYLOAD_BITS-1:0] data;
   logic                    last;

   modport source (output valid, kind, number, data, last, input ready);
   modport sink   (input valid, kind, number, data, last, output ready);
endinterface

FILE: hw/rtl/selective_repeat_receiver.sv
// Selective-repeat receiver: a good request gives an ack and then the in-order deliveries.
// The ack is loaded into the output register from the ACK state and each delivery from DELIVER.
// Each good request gives one ack and d = 0..4 deliveries, one result per cycle through the
// single output register while it is free; a corrupt request gives no result.
// Reset: synchronous, active high; clears window base, received marks and output valid,
// sets window size to 4. The payload store is not cleared.
module selective_repeat_receiver import srr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   srr_req_if.sink             req_ch,
   srr_rsp_if.source           rsp_ch,
   input  logic                csr_wr_en,
   input  logic [WIN_BITS-1:0] csr_wr_data
);
`include "selective_repeat_receiver_assert.svh"

   // The sequencer walks through three phases. IDLE takes a request, stores the payload and
   // sets its mark when it falls in the window. ACK puts the acknowledgement into the output
   // register. While that is free, DELIVER gives one received slot per cycle from the base.
   typedef enum logic [1:0] {IDLE, ACK, DELIVER} state_type;

   state_type               state_ff, state_in;
   logic [SEQ_BITS-1:0]     base_ff, base_in;
   logic [SEQ_SPACE-1:0]    mark_ff, mark_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [WIN_BITS-1:0]     win_ff, win_in;
   logic                    in_win_ff, in_win_in;
   logic [SEQ_BITS-1:0]     seq_ff, seq_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [SEQ_BITS-1:0]     rsp_number_ff, rsp_number_in;
   logic [PAYLOAD_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_fire;
   logic                    out_free;
   logic [WIN_BITS-1:0]     eff_win;
   logic [SEQ_BITS-1:0]     offset;
   logic                    in_win;
   logic                    ram_wr_en;
   logic [PAYLOAD_BITS-1:0] ram_rd_data;
   logic [SEQ_BITS-1:0]     base_next;
   logic                    more;

   assign req_ch.ready = (state_ff == IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // The output register may be reloaded when empty or when its result is taken now.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // A zero window acts as one; anything above half the space saturates there.
   always_comb begin
      eff_win = win_ff;
      if (win_ff == '0) begin
         eff_win = WIN_BITS'(1);
      end else if (win_ff > WIN_RESET) begin
         eff_win = WIN_RESET;
      end
   end

   // Distance from the window base; the subtraction wraps around the sequence space.
   assign offset    = req_ch.seq_num - base_ff;
   assign in_win    = offset < eff_win;
   assign ram_wr_en = req_fire && req_ch.checksum_ok && in_win;
   assign base_next = base_ff + SEQ_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      mark_in       = mark_ff;
      cnt_in        = cnt_ff;
      in_win_in     = in_win_ff;
      seq_in        = seq_ff;
      win_in        = csr_wr_en ? csr_wr_data : win_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_number_in = rsp_number_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      more          = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (req_fire && req_ch.checksum_ok) begin
               seq_in    = req_ch.seq_num;
               in_win_in = in_win;
               if (in_win) begin
                  mark_in[req_ch.seq_num] = 1'b1;
               end
               state_in = ACK;
            end
         end
         ACK: begin
            if (out_free) begin
               // Deliveries follow only if the request landed in the window and the
               // base slot is now complete.
               more          = in_win_ff && mark_ff[base_ff];
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ACK;
               rsp_number_in = seq_ff;
               rsp_data_in   = '0;
               rsp_last_in   = !more;
               cnt_in        = '0;
               state_in      = more ? DELIVER : IDLE;
            end
         end
         DELIVER: begin
            if (out_free) begin
               // The RAM has been reading the base slot since the previous cycle.
               more = (cnt_ff + CNT_BITS'(1) < CNT_BITS'(HALF_SPACE)) && mark_ff[base_next];
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = KIND_DELIVER;
               rsp_number_in    = base_ff;
               rsp_data_in      = ram_rd_data;
               rsp_last_in      = !more;
               mark_in[base_ff] = 1'b0;
               base_in          = base_next;
               cnt_in           = cnt_ff + CNT_BITS'(1);
               state_in         = more ? DELIVER : IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         base_ff      <= '0;
         mark_ff      <= '0;
         cnt_ff       <= '0;
         win_ff       <= WIN_RESET;
         in_win_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         mark_ff      <= mark_in;
         cnt_ff       <= cnt_in;
         win_ff       <= win_in;
         in_win_ff    <= in_win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seq_ff        <= seq_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_number_ff <= rsp_number_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Payload store. Writes happen only in IDLE; the read address tracks the next base so
   // that the registered read data always belongs to the current base slot.
   srr_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_SPACE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_ch.seq_num),
      .wr_data (req_ch.payload),
      .rd_addr (base_in),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.kind   = rsp_kind_ff;
   assign rsp_ch.number = rsp_number_ff;
   assign rsp_ch.data   = rsp_data_ff;
   assign rsp_ch.last   = rsp_last_ff;

   // A delivery phase only ever sits on a slot that has been received.
   `SRR_ASSERT_NOW(a_deliver_marked, clock, reset, state_ff == DELIVER, mark_ff[base_ff], "delivering an unreceived slot")
   // No more than half the space is delivered for one request.
   `SRR_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_BITS'(HALF_SPACE), "delivery count overflow")
   // A good request blocks the input until its results are sequenced.
   `SRR_ASSERT_NEXT(a_busy_after_good, clock, reset, req_fire && req_ch.checksum_ok, !req_ch.ready, "input ready while busy")
   // A corrupt request leaves the window base and marks untouched.
   `SRR_ASSERT_NEXT(a_bad_no_change, clock, reset, req_fire && !req_ch.checksum_ok, $stable(base_ff) && $stable(mark_ff), "corrupt request changed state")
endmodule

FILE: hw/rtl/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module srr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
